// ===== rtl/core/tbp_pkg.sv =====
// Package for the tilt balance PID block: sequencer states, register map and constants.
// It holds the CORDIC arctangent table in Q16 degrees.
// It depends on nothing.
package tbp_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CORDIC,
    ST_ACC,
    ST_RATE_MUL,
    ST_BASE,
    ST_GYRO_MUL,
    ST_ACC_MUL,
    ST_ANGLE,
    ST_ERR,
    ST_SUM,
    ST_P_MUL,
    ST_I_MUL,
    ST_D_MUL,
    ST_DRIVE,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_ALPHA  = 3'd1,
    REG_GSTEP  = 3'd2,
    REG_PGAIN  = 3'd3,
    REG_IGAIN  = 3'd4,
    REG_DGAIN  = 3'd5,
    REG_ILIMIT = 3'd6,
    REG_NONE   = 3'd7
  } reg_e;

  localparam int TableLen = 24;
  localparam logic signed [25:0] Ang90 = 26'sd5898240;
  localparam logic signed [23:0] AngleMax = 24'sd46080;
  localparam logic [16:0] GyroDiv = 17'd65535;
  localparam logic signed [9:0] RateOffset = 10'sd250;

  function automatic logic [22:0] atan_q16(input logic [4:0] idx);
    logic [22:0] v;
    case (idx)
      5'd0:  v = 23'd2949120;
      5'd1:  v = 23'd1740967;
      5'd2:  v = 23'd919879;
      5'd3:  v = 23'd466945;
      5'd4:  v = 23'd234379;
      5'd5:  v = 23'd117304;
      5'd6:  v = 23'd58666;
      5'd7:  v = 23'd29335;
      5'd8:  v = 23'd14668;
      5'd9:  v = 23'd7334;
      5'd10: v = 23'd3667;
      5'd11: v = 23'd1833;
      5'd12: v = 23'd917;
      5'd13: v = 23'd458;
      5'd14: v = 23'd229;
      5'd15: v = 23'd115;
      5'd16: v = 23'd57;
      5'd17: v = 23'd29;
      5'd18: v = 23'd14;
      5'd19: v = 23'd7;
      5'd20: v = 23'd4;
      5'd21: v = 23'd2;
      5'd22: v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/tilt_balance_pid.sv =====
// Top level of the tilt balance PID block: CORDIC tilt, complementary filter and PID drive.
// One shared multiplier and one shift-add CORDIC stage run under a small sequencer.
// It depends on tbp_pkg.
//
//   Channel  | Direction | Payload
//   s_axis   | in        | accel_y, accel_z, gyro_x
//   m_axis   | out       | motor_drive, motor_duty, motor_forward, tilt_angle, heartbeat_led
//   APB      | in/out    | seven gain and setpoint registers at byte address 4*i
//
// Each word runs through pre-rotation, min(CORDIC_STEPS, 24) iterations of the single
// shift-add CORDIC stage, and then the filter, PID and drive states before its result.
// The input is not ready from acceptance until the result is loaded into the output register.
// A result that is not taken stalls the sequencer in its last state only.
// Reset clears the control state, the filter and PID history and the registers to defaults.
module tilt_balance_pid #(
  parameter int CORDIC_STEPS = 16,
  parameter int TOGGLE_TICKS = 200
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // accel_y [15:0], accel_z [31:16], gyro_x [47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // motor_drive [8:0], motor_duty [16:9], motor_forward [17], tilt_angle [34:18],
  // heartbeat_led [35], zero [39:36]
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NSteps = (CORDIC_STEPS < tbp_pkg::TableLen) ? CORDIC_STEPS : tbp_pkg::TableLen;
  localparam int CW = $clog2(NSteps);

  tbp_pkg::state_e state_q, state_d;

  logic signed [16:0] target_q;
  logic [16:0] alpha_q;
  logic [15:0] gstep_q;
  logic [17:0] pgain_q, igain_q, dgain_q;
  logic [16:0] ilimit_q;

  logic signed [15:0] ay_q, az_q, gx_q;
  logic signed [26:0] x_q, y_q;
  logic signed [25:0] ang_q;
  logic zero_q;
  logic [CW-1:0] cnt_q;
  logic signed [8:0] rate_q;
  logic signed [16:0] acc_q;
  logic signed [25:0] base_q;
  logic signed [46:0] prod_q;
  logic signed [47:0] accum_q;
  logic signed [16:0] angle_q, last_angle_q;
  logic signed [17:0] err_q, last_err_q, esum_q;
  logic signed [18:0] diff_q;
  logic [7:0] tick_q;
  logic led_q;
  logic [7:0] duty_q;
  logic neg_q;
  logic m_valid_q;
  logic [39:0] m_data_q;

  logic signed [26:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [46:0] prod_d;
  logic cfg_wr;
  tbp_pkg::reg_e cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign cfg_idx = tbp_pkg::reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= -17'sd10163;
      alpha_q  <= 17'd65103;
      gstep_q  <= 16'd328;
      pgain_q  <= 18'd16640;
      igain_q  <= 18'd358;
      dgain_q  <= 18'd71680;
      ilimit_q <= 17'd76800;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tbp_pkg::REG_TARGET: target_q <= $signed(pwdata[16:0]);
        tbp_pkg::REG_ALPHA:  alpha_q  <= pwdata[16:0];
        tbp_pkg::REG_GSTEP:  gstep_q  <= pwdata[15:0];
        tbp_pkg::REG_PGAIN:  pgain_q  <= pwdata[17:0];
        tbp_pkg::REG_IGAIN:  igain_q  <= pwdata[17:0];
        tbp_pkg::REG_DGAIN:  dgain_q  <= pwdata[17:0];
        tbp_pkg::REG_ILIMIT: ilimit_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tbp_pkg::REG_TARGET: prdata = {15'd0, target_q};
      tbp_pkg::REG_ALPHA:  prdata = {15'd0, alpha_q};
      tbp_pkg::REG_GSTEP:  prdata = {16'd0, gstep_q};
      tbp_pkg::REG_PGAIN:  prdata = {14'd0, pgain_q};
      tbp_pkg::REG_IGAIN:  prdata = {14'd0, igain_q};
      tbp_pkg::REG_DGAIN:  prdata = {14'd0, dgain_q};
      tbp_pkg::REG_ILIMIT: prdata = {15'd0, ilimit_q};
      default:             prdata = 32'd0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tbp_pkg::ST_IDLE:     if (s_axis_tvalid) state_d = tbp_pkg::ST_PREP;
      tbp_pkg::ST_PREP:     state_d = tbp_pkg::ST_CORDIC;
      tbp_pkg::ST_CORDIC:   if (cnt_q == CW'(NSteps - 1)) state_d = tbp_pkg::ST_ACC;
      tbp_pkg::ST_ACC:      state_d = tbp_pkg::ST_RATE_MUL;
      tbp_pkg::ST_RATE_MUL: state_d = tbp_pkg::ST_BASE;
      tbp_pkg::ST_BASE:     state_d = tbp_pkg::ST_GYRO_MUL;
      tbp_pkg::ST_GYRO_MUL: state_d = tbp_pkg::ST_ACC_MUL;
      tbp_pkg::ST_ACC_MUL:  state_d = tbp_pkg::ST_ANGLE;
      tbp_pkg::ST_ANGLE:    state_d = tbp_pkg::ST_ERR;
      tbp_pkg::ST_ERR:      state_d = tbp_pkg::ST_SUM;
      tbp_pkg::ST_SUM:      state_d = tbp_pkg::ST_P_MUL;
      tbp_pkg::ST_P_MUL:    state_d = tbp_pkg::ST_I_MUL;
      tbp_pkg::ST_I_MUL:    state_d = tbp_pkg::ST_D_MUL;
      tbp_pkg::ST_D_MUL:    state_d = tbp_pkg::ST_DRIVE;
      tbp_pkg::ST_DRIVE:    state_d = tbp_pkg::ST_DONE;
      tbp_pkg::ST_DONE:     if (!m_valid_q || m_axis_tready) state_d = tbp_pkg::ST_IDLE;
      default:              state_d = tbp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == tbp_pkg::ST_IDLE);
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      tbp_pkg::ST_RATE_MUL: begin
        mul_a = {11'd0, gstep_q};
        mul_b = 20'(rate_q);
      end
      tbp_pkg::ST_GYRO_MUL: begin
        mul_a = 27'(base_q);
        mul_b = {3'd0, alpha_q};
      end
      tbp_pkg::ST_ACC_MUL: begin
        mul_a = 27'($signed({acc_q, 8'd0}));
        mul_b = 20'($signed(18'd65536 - {1'b0, alpha_q}));
      end
      tbp_pkg::ST_P_MUL: begin
        mul_a = 27'(err_q);
        mul_b = {2'd0, pgain_q};
      end
      tbp_pkg::ST_I_MUL: begin
        mul_a = 27'(esum_q);
        mul_b = {2'd0, igain_q};
      end
      tbp_pkg::ST_D_MUL: begin
        mul_a = 27'(diff_q);
        mul_b = {2'd0, dgain_q};
      end
      default: ;
    endcase
  end

  assign prod_d = 47'(mul_a) * 47'(mul_b);

  // Pre-rotation, gyro mapping, CORDIC step and the later fixed-point steps.
  logic signed [26:0] xs, ys, dx, dy;
  logic [15:0] gu;
  logic [24:0] gn;
  logic [8:0] gq;
  logic [16:0] grem;
  logic signed [9:0] rate_w;
  logic signed [25:0] atan_w, acc_round;
  logic signed [47:0] s_w, pid_w, mag_w;
  logic signed [23:0] ang_w;
  logic signed [18:0] esum_w, lim_w;
  logic [31:0] drv_w;
  logic [7:0] tick_inc;

  always_comb begin
    xs = 27'($signed({az_q, 8'd0}));
    ys = 27'($signed({ay_q, 8'd0}));
    dx = y_q >>> cnt_q;
    dy = x_q >>> cnt_q;
    atan_w = $signed({3'd0, tbp_pkg::atan_q16(5'(cnt_q))});
    gu = {~gx_q[15], gx_q[14:0]};
    gn = ({9'd0, gu} << 9) - ({9'd0, gu} << 3) - ({9'd0, gu} << 2);
    gq = gn[24:16];
    grem = {1'b0, gn[15:0]} + {8'd0, gq};
    rate_w = $signed({1'b0, gq}) + ((grem >= tbp_pkg::GyroDiv) ? 10'sd1 : 10'sd0)
             - tbp_pkg::RateOffset;
    acc_round = ang_q + 26'sd128;
    s_w = accum_q + 48'(prod_q) + 48'sd8388608;
    ang_w = s_w[47:24];
    esum_w = 19'(esum_q) + 19'(err_q);
    lim_w = $signed({2'd0, ilimit_q});
    pid_w = accum_q + 48'(prod_q);
    mag_w = pid_w[47] ? -pid_w : pid_w;
    drv_w = mag_w[47:16];
    tick_inc = tick_q + 8'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tbp_pkg::ST_IDLE;
      cnt_q        <= '0;
      last_angle_q <= '0;
      last_err_q   <= '0;
      esum_q       <= '0;
      tick_q       <= '0;
      led_q        <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == tbp_pkg::ST_DONE) && (!m_valid_q || m_axis_tready)) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
      case (state_q)
        tbp_pkg::ST_PREP:   cnt_q <= '0;
        tbp_pkg::ST_CORDIC: cnt_q <= cnt_q + CW'(1);
        tbp_pkg::ST_SUM: begin
          if (esum_w > lim_w) esum_q <= 18'(lim_w);
          else if (esum_w < -lim_w) esum_q <= 18'(-lim_w);
          else esum_q <= 18'(esum_w);
          last_err_q   <= err_q;
          last_angle_q <= angle_q;
        end
        tbp_pkg::ST_DRIVE: begin
          if (tick_inc == 8'(TOGGLE_TICKS)) begin
            tick_q <= '0;
            led_q  <= ~led_q;
          end else begin
            tick_q <= tick_inc;
          end
        end
        default: ;
      endcase
    end
  end

  logic [7:0] drive_mag;
  assign drive_mag = duty_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      tbp_pkg::ST_IDLE: begin
        ay_q <= $signed(s_axis_tdata[15:0]);
        az_q <= $signed(s_axis_tdata[31:16]);
        gx_q <= $signed(s_axis_tdata[47:32]);
      end
      tbp_pkg::ST_PREP: begin
        zero_q <= (ay_q == 16'sd0) && (az_q == 16'sd0);
        rate_q <= 9'(rate_w);
        if (xs < 0) begin
          if (ys >= 0) begin
            x_q <= ys;
            y_q <= -xs;
            ang_q <= tbp_pkg::Ang90;
          end else begin
            x_q <= -ys;
            y_q <= xs;
            ang_q <= -tbp_pkg::Ang90;
          end
        end else begin
          x_q <= xs;
          y_q <= ys;
          ang_q <= '0;
        end
      end
      tbp_pkg::ST_CORDIC: begin
        if (y_q > 0) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          ang_q <= ang_q + atan_w;
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          ang_q <= ang_q - atan_w;
        end
      end
      tbp_pkg::ST_ACC: acc_q <= zero_q ? 17'sd0 : $signed(acc_round[24:8]);
      tbp_pkg::ST_BASE: base_q <= 26'($signed({last_angle_q, 8'd0})) + prod_q[25:0];
      tbp_pkg::ST_ACC_MUL: accum_q <= 48'(prod_q);
      tbp_pkg::ST_ANGLE: begin
        if (ang_w > tbp_pkg::AngleMax) angle_q <= 17'(tbp_pkg::AngleMax);
        else if (ang_w < -tbp_pkg::AngleMax) angle_q <= 17'(-tbp_pkg::AngleMax);
        else angle_q <= 17'(ang_w);
      end
      tbp_pkg::ST_ERR: err_q <= 18'(angle_q) - 18'(target_q);
      tbp_pkg::ST_SUM: diff_q <= 19'(err_q) - 19'(last_err_q);
      tbp_pkg::ST_I_MUL: accum_q <= 48'(prod_q);
      tbp_pkg::ST_D_MUL: accum_q <= accum_q + 48'(prod_q);
      tbp_pkg::ST_DRIVE: begin
        duty_q <= (drv_w > 32'd255) ? 8'd255 : drv_w[7:0];
        neg_q  <= pid_w[47];
      end
      tbp_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_q <= {4'd0, led_q, angle_q, ~(neg_q && (drive_mag != 8'd0)), drive_mag,
                       neg_q ? 9'(-{1'b0, drive_mag}) : {1'b0, drive_mag}};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== rtl/core/tbp_checker.sv =====
// Port-level checker for the tilt balance PID block, bound to its top level.
// It depends on tilt_balance_pid.
module tbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        pready
);

  logic signed [16:0] tilt;
  logic [8:0] drive;
  logic [8:0] signed_duty;

  assign tilt = $signed(m_axis_tdata[34:18]);
  assign drive = m_axis_tdata[8:0];
  assign signed_duty = m_axis_tdata[17] ? {1'b0, m_axis_tdata[16:9]}
                                        : 9'(-{1'b0, m_axis_tdata[16:9]});

  a_tilt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (tilt <= 17'sd46080) && (tilt >= -17'sd46080))
    else $error("tilt angle out of range");

  a_drive_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (drive == signed_duty) && (drive != 9'h100))
    else $error("drive, duty and direction disagree");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind tilt_balance_pid tbp_checker u_tbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

// ===== sim/tilt_balance_pid_tb.sv =====
// Self-checking testbench for tilt_balance_pid: random and directed sensor words with APB setups.
// A scoreboard class predicts every output word in 64-bit arithmetic and checks it field by field.
// It depends on tbp_pkg and tilt_balance_pid.
`timescale 1ns / 1ps

module tilt_balance_pid_tb;

  typedef struct {
    logic signed [8:0]  drive;
    logic [7:0]         duty;
    logic               forward;
    logic signed [16:0] angle;
    logic               led;
  } drive_word_t;

  localparam int WatchLimit = 3000;
  localparam int HoldCycles = 300;
  localparam int Toggle     = 200;

  class tilt_scoreboard;
    longint target, alpha, gstep, kp, ki, kd, ilimit;
    longint prev_angle, prev_err, err_sum;
    int     ticks;
    bit     led;
    int     errors;
    drive_word_t pending_q[$];

    function new();
      target = -10163; alpha = 65103; gstep = 328; kp = 16640;
      ki = 358; kd = 71680; ilimit = 76800;
      prev_angle = 0; prev_err = 0; err_sum = 0; ticks = 0; led = 0; errors = 0;
    endfunction

    function void write_reg(tbp_pkg::reg_e idx, logic [31:0] v);
      case (idx)
        tbp_pkg::REG_TARGET: target = longint'($signed(v[16:0]));
        tbp_pkg::REG_ALPHA:  alpha  = longint'(v[16:0]);
        tbp_pkg::REG_GSTEP:  gstep  = longint'(v[15:0]);
        tbp_pkg::REG_PGAIN:  kp     = longint'(v[17:0]);
        tbp_pkg::REG_IGAIN:  ki     = longint'(v[17:0]);
        tbp_pkg::REG_DGAIN:  kd     = longint'(v[17:0]);
        tbp_pkg::REG_ILIMIT: ilimit = longint'(v[16:0]);
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint accel_tilt(longint y, longint z);
      longint x, t, ang, dx, dy;
      ang = 0;
      if (y == 0 && z == 0) return 0;
      x = z * 256;
      y = y * 256;
      if (x < 0) begin
        if (y >= 0) begin
          t = y; y = -x; x = t; ang = 90 * 65536;
        end else begin
          t = -y; y = x; x = t; ang = -90 * 65536;
        end
      end
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; ang += longint'(tbp_pkg::atan_q16(i[4:0]));
        end else begin
          x -= dx; y += dy; ang -= longint'(tbp_pkg::atan_q16(i[4:0]));
        end
      end
      return (ang + 128) >>> 8;
    endfunction

    function void note_input(logic [47:0] d);
      longint acc, rate, s, angle, err, pid, drive;
      drive_word_t w;
      acc   = accel_tilt(longint'($signed(d[15:0])), longint'($signed(d[31:16])));
      rate  = ((longint'($signed(d[47:32])) + 32768) * 500) / 65535 - 250;
      s     = alpha * (prev_angle * 256 + rate * gstep) + (65536 - alpha) * acc * 256;
      angle = clip((s + 8388608) >>> 24, -46080, 46080);
      err   = clip(angle - target, -131072, 131071);
      err_sum = clip(err_sum + err, -ilimit, ilimit);
      pid   = kp * err + ki * err_sum + kd * (err - prev_err);
      drive = clip(pid / 65536, -255, 255);
      prev_angle = angle;
      prev_err   = err;
      ticks++;
      if (ticks == Toggle) begin
        ticks = 0;
        led = !led;
      end
      w.drive   = drive[8:0];
      w.duty    = drive < 0 ? 8'(-drive) : 8'(drive);
      w.forward = drive >= 0;
      w.angle   = angle[16:0];
      w.led     = led;
      pending_q.push_back(w);
    endfunction

    function void check_result(logic [39:0] d);
      drive_word_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, d);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (d[8:0] !== e.drive) begin
        $display("%0t: motor_drive expected %0d actual %0d", $time, e.drive,
                 $signed(d[8:0]));
        errors++;
      end
      if (d[16:9] !== e.duty) begin
        $display("%0t: motor_duty expected %0d actual %0d", $time, e.duty, d[16:9]);
        errors++;
      end
      if (d[17] !== e.forward) begin
        $display("%0t: motor_forward expected %0b actual %0b", $time, e.forward, d[17]);
        errors++;
      end
      if (d[34:18] !== e.angle) begin
        $display("%0t: tilt_angle expected %0d actual %0d", $time, e.angle,
                 $signed(d[34:18]));
        errors++;
      end
      if (d[35] !== e.led) begin
        $display("%0t: heartbeat_led expected %0b actual %0b", $time, e.led, d[35]);
        errors++;
      end
      if (d[39:36] !== 4'd0) begin
        $display("%0t: padding expected 0 actual %h", $time, d[39:36]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tilt_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  holding = 1'b0;
  int  quiet = 0;

  tilt_balance_pid uut (.*);

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) m_axis_tready = !holding && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel
        || !rst_ni) quiet = 0;
    else quiet++;
    if (quiet > WatchLimit) begin
      $display("tilt_balance_pid_tb: FAIL");
      $finish;
    end
  end

  task automatic apb_write(tbp_pkg::reg_e idx, logic [31:0] v);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = {idx, 2'b00}; pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, v);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic send_word(logic [15:0] ay, logic [15:0] az, logic [15:0] gx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {gx, az, ay};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    int k;
    k = $urandom_range(9);
    if (k < 6) begin
      send_word(16'($signed($urandom_range(12000)) - 6000),
                16'(($urandom_range(1) ? 1 : -1) * $signed($urandom_range(20000, 10000))),
                16'($signed($urandom_range(4000)) - 2000));
    end else if (k < 9) begin
      send_word(16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      send_word($urandom_range(1) ? 16'h8000 : 16'h7fff,
                $urandom_range(2) == 0 ? 16'h0 : 16'($urandom),
                $urandom_range(1) ? 16'h8000 : 16'h7fff);
    end
  endtask

  task automatic wait_empty();
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    wait_empty();
    repeat (60) @(negedge clk_i);
  endtask

  task automatic configure(int phase);
    case (phase)
      1: begin
        apb_write(tbp_pkg::REG_TARGET, 32'(-46080)); apb_write(tbp_pkg::REG_ALPHA, 0);
        apb_write(tbp_pkg::REG_GSTEP, 65535); apb_write(tbp_pkg::REG_PGAIN, 262143);
        apb_write(tbp_pkg::REG_IGAIN, 262143); apb_write(tbp_pkg::REG_DGAIN, 262143);
        apb_write(tbp_pkg::REG_ILIMIT, 131071);
      end
      2: begin
        apb_write(tbp_pkg::REG_TARGET, 46080); apb_write(tbp_pkg::REG_ALPHA, 65536);
        apb_write(tbp_pkg::REG_GSTEP, 0); apb_write(tbp_pkg::REG_PGAIN, 0);
        apb_write(tbp_pkg::REG_IGAIN, 0); apb_write(tbp_pkg::REG_DGAIN, 0);
        apb_write(tbp_pkg::REG_ILIMIT, 0);
      end
      3: begin
        apb_write(tbp_pkg::REG_ALPHA, 131071); apb_write(tbp_pkg::REG_TARGET, 32'h0001ffff);
        apb_write(tbp_pkg::REG_NONE, $urandom);
      end
      default: begin
        apb_write(tbp_pkg::REG_TARGET, $urandom);
        apb_write(tbp_pkg::REG_ALPHA, $urandom_range(65536));
        apb_write(tbp_pkg::REG_GSTEP, $urandom_range(2000));
        apb_write(tbp_pkg::REG_PGAIN, $urandom_range(40000));
        apb_write(tbp_pkg::REG_IGAIN, $urandom_range(2000));
        apb_write(tbp_pkg::REG_DGAIN, $urandom);
        apb_write(tbp_pkg::REG_ILIMIT, $urandom);
      end
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_word(16'h0000, 16'h0000, 16'h0000);
    send_word(16'h7fff, 16'h7fff, 16'h7fff);
    send_word(16'h8000, 16'h8000, 16'h8000);
    send_word(16'h7fff, 16'h8000, 16'h0000);
    send_word(16'h8000, 16'h7fff, 16'hffff);
    send_word(16'h0000, 16'h8000, 16'h0001);
    send_word(16'h0001, 16'hffff, 16'h7fff);
    send_word(16'hffff, 16'hffff, 16'h8000);
    send_word(16'h4000, 16'h0000, 16'h0000);
    send_word(16'hc000, 16'h0000, 16'h0000);
    send_word(16'h0000, 16'h4000, 16'h1234);
    send_word(16'h1000, 16'h4000, 16'hedcb);
    send_word(16'hf000, 16'hc000, 16'h0000);
    send_word(16'h0001, 16'h0000, 16'h0000);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      configure(phase);
      send_idle_pct  = (phase % 4 == 1 || phase % 4 == 3) ? (phase % 4 == 1 ? 47 : 13) : 0;
      recv_stall_pct = (phase % 4 == 2 || phase % 4 == 3) ? (phase % 4 == 2 ? 47 : 13) : 0;
      for (int n = 0; n < 210; n++) begin
        if (phase == 5 && n == 20) begin
          fork
            begin
              holding = 1'b1;
              repeat (HoldCycles) @(negedge clk_i);
              holding = 1'b0;
            end
          join_none
        end
        if (phase == 6 && n == 100) begin
          s_axis_tvalid = 1'b0;
          wait_empty();
          @(negedge clk_i);
        end
        send_random();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("tilt_balance_pid_tb: PASS");
    end else begin
      $display("tilt_balance_pid_tb: FAIL");
    end
    $finish;
  end

endmodule
